FILE: rtl/afr_pkg.sv
// Shared types and constants for the API frame receiver.
package afr_pkg;

   localparam int MAX_FRAME = 256;
   // position covers hunting, the length bytes and up to MAX_FRAME + 1
   localparam int POS_W = $clog2(MAX_FRAME + 2);
   localparam int LEN_W = 16;
   localparam int CMP_W = (POS_W > LEN_W + 1) ? POS_W : LEN_W + 1;

   localparam logic [7:0] START_RESET  = 8'h7E;
   localparam logic [7:0] ESCAPE_RESET = 8'h7D;
   localparam logic [7:0] ESCAPE_XOR   = 8'h20;
   localparam logic [7:0] SUM_GOOD     = 8'hFF;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_START  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE = 1'b1;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_GOOD     = 3'd1,
      KIND_BAD_SUM  = 3'd2,
      KIND_DELIM    = 3'd3,
      KIND_OVERSIZE = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data_byte;
      logic [7:0]       data_index;
      logic [7:0]       api_id;
      logic [LEN_W-1:0] frame_length;
      logic             last;
   } result_type;

endpackage

FILE: rtl/afr_input_reg.sv
// Input register stage holding one received byte.
module afr_input_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       in_valid,
   output logic [7:0] in_byte
);
   import afr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

FILE: rtl/afr_deframer.sv
// Frame state, unescaping, checksum and result decision for one byte.
module afr_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [afr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [afr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               in_valid,
   input  logic [7:0]                         in_byte,
   input  logic                               out_ready,
   output logic                               take,
   output logic                               result_valid,
   output afr_pkg::result_type                result
);
   import afr_pkg::*;

   logic [7:0]       start_ff, escape_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             esc_ff, esc_in;
   logic [7:0]       first_ff, first_in;

   logic [7:0]       b;
   logic [7:0]       sum_next;
   logic             has_result;
   logic             at_end;
   logic [POS_W-1:0] data_pos;

   assign take     = in_valid && out_ready;
   assign b        = esc_ff ? (in_byte ^ ESCAPE_XOR) : in_byte;
   assign sum_next = sum_ff + b;
   assign at_end   = (CMP_W'(pos_ff) == (CMP_W'(len_ff) + CMP_W'(3)));
   assign data_pos = pos_ff - POS_W'(3);

   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      len_in     = len_ff;
      esc_in     = esc_ff;
      first_in   = first_ff;
      has_result = 1'b0;
      result     = '{kind: KIND_DATA, data_byte: 8'd0, data_index: 8'd0,
                     api_id: 8'd0, frame_length: len_ff, last: 1'b0};
      if (pos_ff == '0) begin
         if (in_byte == start_ff) begin
            pos_in   = POS_W'(1);
            sum_in   = '0;
            len_in   = '0;
            esc_in   = 1'b0;
            first_in = '0;
         end
      end else if (!esc_ff && in_byte == start_ff) begin
         has_result  = 1'b1;
         result.kind = KIND_DELIM;
         result.last = 1'b1;
         pos_in      = POS_W'(1);
         sum_in      = '0;
         len_in      = '0;
         esc_in      = 1'b0;
         first_in    = '0;
      end else if (!esc_ff && in_byte == escape_ff) begin
         esc_in = 1'b1;
      end else begin
         esc_in = 1'b0;
         if (pos_ff > POS_W'(MAX_FRAME)) begin
            has_result  = 1'b1;
            result.kind = KIND_OVERSIZE;
            result.last = 1'b1;
            pos_in      = '0;
         end else if (pos_ff == POS_W'(1)) begin
            len_in = {b, 8'd0};
            pos_in = POS_W'(2);
         end else if (pos_ff == POS_W'(2)) begin
            len_in = {len_ff[LEN_W-1:8], b};
            pos_in = POS_W'(3);
         end else begin
            sum_in     = sum_next;
            has_result = 1'b1;
            if (at_end) begin
               result.kind = (sum_next == SUM_GOOD) ? KIND_GOOD : KIND_BAD_SUM;
               result.api_id = (sum_next == SUM_GOOD) ? first_ff : 8'd0;
               result.last = 1'b1;
               pos_in      = '0;
            end else begin
               if (pos_ff == POS_W'(3)) first_in = b;
               result.data_byte  = b;
               result.data_index = data_pos[7:0];
               pos_in            = pos_ff + POS_W'(1);
            end
         end
      end
   end

   assign result_valid = take && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_RESET;
         escape_ff <= ESCAPE_RESET;
         pos_ff    <= '0;
         sum_ff    <= '0;
         len_ff    <= '0;
         esc_ff    <= 1'b0;
         first_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_START:  start_ff  <= csr_write_data;
               CSR_ESCAPE: escape_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (take) begin
            pos_ff   <= pos_in;
            sum_ff   <= sum_in;
            len_ff   <= len_in;
            esc_ff   <= esc_in;
            first_ff <= first_in;
         end
      end
   end

   a_esc_in_frame: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> pos_ff != '0)
      else $error("escape pending while hunting");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_FRAME + 1))
      else $error("position past oversize limit");

   a_end_resets_pos: assert property (@(posedge clock) disable iff (reset)
      result_valid && result.last |=> pos_ff == '0 || pos_ff == POS_W'(1))
      else $error("frame end did not restart hunting or a new frame");

   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      result_valid && result.kind == KIND_DATA |-> !result.last)
      else $error("data transaction flagged as last");

endmodule

FILE: rtl/afr_output_reg.sv
// Result register driving the response channel.
module afr_output_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  afr_pkg::result_type          result,
   output logic                         out_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_kind,
   output logic [7:0]                   rsp_data_byte,
   output logic [7:0]                   rsp_data_index,
   output logic [7:0]                   rsp_api_id,
   output logic [afr_pkg::LEN_W-1:0]    rsp_frame_length,
   output logic                         rsp_last
);
   import afr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = data_ff.kind;
   assign rsp_data_byte    = data_ff.data_byte;
   assign rsp_data_index   = data_ff.data_index;
   assign rsp_api_id       = data_ff.api_id;
   assign rsp_frame_length = data_ff.frame_length;
   assign rsp_last         = data_ff.last;

endmodule

FILE: rtl/api_frame_receiver.sv
// Escaped API frame receiver: bytes in, decoded data and frame status out.
//
// Request channel: one raw link byte per transaction on req_rx_byte,
// qualified by req_valid and held off by req_stall.
// Response channel: zero or one transaction per byte. Data bytes come out
// with kind data, their index and last low; each frame ends with one status
// transaction (good, bad checksum, delimiter inside frame, oversize) with
// last high, the frame length and, for a good frame, the API id.
// csr_write_enable writes start_value (index 0) or escape_value (index 1);
// write only while the block is idle.
// Path: a taken byte waits in the input register, then the combinational
// decode step loads its result into the result register, which drives the
// response channel.
// Throughput: one byte per cycle while rsp_stall is low; the combinational
// decode step and its small state registers allow that rate.
// Reset clears frame state (hunting for a delimiter) and restores the
// delimiter 0x7E and escape 0x7D. No clearing pass is needed.
// When the receiver stalls, the result register holds; one further byte
// waits in the input register, then req_stall rises.
module api_frame_receiver (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [afr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [afr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_kind,
   output logic [7:0]                         rsp_data_byte,
   output logic [7:0]                         rsp_data_index,
   output logic [7:0]                         rsp_api_id,
   output logic [afr_pkg::LEN_W-1:0]          rsp_frame_length,
   output logic                               rsp_last
);
   import afr_pkg::*;

   logic       take;
   logic       in_valid;
   logic [7:0] in_byte;
   logic       out_ready;
   logic       result_valid;
   result_type result;

   afr_input_reg u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   afr_deframer u_deframer (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_valid         (in_valid),
      .in_byte          (in_byte),
      .out_ready        (out_ready),
      .take             (take),
      .result_valid     (result_valid),
      .result           (result)
   );

   afr_output_reg u_output (
      .clock            (clock),
      .reset            (reset),
      .load             (result_valid),
      .result           (result),
      .out_ready        (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_index   (rsp_data_index),
      .rsp_api_id       (rsp_api_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: sim/tb_api_frame_receiver.sv
// Self-checking testbench for the API frame receiver: random framed byte streams, result compare.
`timescale 1ns / 1ps

module tb_api_frame_receiver;
   import afr_pkg::*;

   localparam int LIMIT      = 400000;
   localparam int PHASE_LOAD = 130;
   localparam int SHOW_MAX   = 40;

   // Tracks frame decode state and holds the results the block owes us.
   class deframe_checker;
      logic [7:0]       start_val;
      logic [7:0]       esc_val;
      logic [POS_W-1:0] position;
      logic [7:0]       running_sum;
      logic [LEN_W-1:0] length_val;
      logic             esc_pending;
      logic [7:0]       first_byte;
      result_type       pending_results[$];
      int               mismatches;
      int               checked;
      int               ends_seen[5];

      function new();
         start_val   = START_RESET;
         esc_val     = ESCAPE_RESET;
         position    = '0;
         running_sum = '0;
         length_val  = '0;
         esc_pending = 1'b0;
         first_byte  = '0;
         mismatches  = 0;
         checked     = 0;
         foreach (ends_seen[i]) ends_seen[i] = 0;
      endfunction

      function void open_frame();
         position    = POS_W'(1);
         running_sum = '0;
         length_val  = '0;
         esc_pending = 1'b0;
         first_byte  = '0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= SHOW_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      // Advance the decoder by one accepted byte; queue the result it causes, if any.
      function void take_byte(logic [7:0] raw);
         logic [7:0]       b;
         result_type       r;
         logic [POS_W-1:0] idx;
         logic             good;
         b = raw;
         r = '0;
         if (position == '0) begin
            if (b == start_val) open_frame();
            return;
         end
         if (esc_pending) begin
            b = b ^ ESCAPE_XOR;
            esc_pending = 1'b0;
         end else if (b == start_val) begin
            r.kind = KIND_DELIM;
            r.frame_length = length_val;
            r.last = 1'b1;
            pending_results.push_back(r);
            open_frame();
            return;
         end else if (b == esc_val) begin
            esc_pending = 1'b1;
            return;
         end
         if (position > MAX_FRAME) begin
            position = '0;
            r.kind = KIND_OVERSIZE;
            r.frame_length = length_val;
            r.last = 1'b1;
            pending_results.push_back(r);
            return;
         end
         if (position == POS_W'(1)) begin
            length_val = {b, 8'h00};
            position = POS_W'(2);
            return;
         end
         if (position == POS_W'(2)) begin
            length_val[7:0] = b;
            position = POS_W'(3);
            return;
         end
         running_sum = running_sum + b;
         if (CMP_W'(position) == CMP_W'(length_val) + CMP_W'(3)) begin
            good = (running_sum == SUM_GOOD);
            position = '0;
            r.kind = good ? KIND_GOOD : KIND_BAD_SUM;
            r.api_id = good ? first_byte : 8'h00;
            r.frame_length = length_val;
            r.last = 1'b1;
            pending_results.push_back(r);
            return;
         end
         if (position == POS_W'(3)) first_byte = b;
         idx = position - POS_W'(3);
         r.kind = KIND_DATA;
         r.data_byte = b;
         r.data_index = idx[7:0];
         r.frame_length = length_val;
         pending_results.push_back(r);
         position = position + POS_W'(1);
      endfunction

      task match_result(logic [2:0] kind, logic [7:0] data, logic [7:0] idx,
                        logic [7:0] api, logic [LEN_W-1:0] len, logic last);
         result_type e;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d data %h idx %0d",
                                      kind, data, idx));
            return;
         end
         e = pending_results.pop_front();
         checked++;
         if (e.kind != KIND_DATA) ends_seen[e.kind]++;
         if (kind !== e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
         if (data !== e.data_byte)
            report_mismatch($sformatf("data_byte %h, want %h", data, e.data_byte));
         if (idx !== e.data_index)
            report_mismatch($sformatf("data_index %0d, want %0d", idx, e.data_index));
         if (api !== e.api_id)
            report_mismatch($sformatf("api_id %h, want %h", api, e.api_id));
         if (len !== e.frame_length)
            report_mismatch($sformatf("frame_length %h, want %h", len, e.frame_length));
         if (last !== e.last)
            report_mismatch($sformatf("last %b, want %b", last, e.last));
      endtask
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_START;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_rx_byte      = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [2:0]             rsp_kind;
   logic [7:0]             rsp_data_byte;
   logic [7:0]             rsp_data_index;
   logic [7:0]             rsp_api_id;
   logic [LEN_W-1:0]       rsp_frame_length;
   logic                   rsp_last;

   deframe_checker tracker = new();
   logic [7:0]     stim_q[$];
   bit             calm = 1'b0;
   int             stall_left = 0;
   int             bytes_sent = 0;
   int             settings_used = 1;
   int             cycle_count = 0;

   api_frame_receiver DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_index   (rsp_data_index),
      .rsp_api_id       (rsp_api_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic int pick_wait();
      if (calm || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 13);
   endfunction

   // Result side: check each accepted transaction, then hold off for a random stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            tracker.match_result(rsp_kind, rsp_data_byte, rsp_data_index, rsp_api_id,
                                 rsp_frame_length, rsp_last);
            stall_left = pick_wait();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_byte(logic [7:0] b);
      int gap;
      if ($urandom_range(0, 63) == 0) calm = ~calm;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_byte(b);
      bytes_sent++;
   endtask

   task automatic send_all();
      while (stim_q.size() != 0) send_byte(stim_q.pop_front());
      req_valid <= 1'b0;
   endtask

   // Idle means no result owed and the pipeline drained of bytes that give none.
   task automatic wait_idle();
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_settings(logic [7:0] s, logic [7:0] e);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_START;
      csr_write_data   <= s;
      @(posedge clock);
      tracker.start_val = s;
      csr_index        <= CSR_ESCAPE;
      csr_write_data   <= e;
      @(posedge clock);
      tracker.esc_val = e;
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // When delimiter and escape differ, escape both values, and now and then any other byte.
   function automatic void add_coded(logic [7:0] b);
      if (tracker.start_val != tracker.esc_val &&
          (b == tracker.start_val || b == tracker.esc_val || $urandom_range(0, 15) == 0)) begin
         stim_q.push_back(tracker.esc_val);
         stim_q.push_back(b ^ ESCAPE_XOR);
      end else begin
         stim_q.push_back(b);
      end
   endfunction

   // One frame; cut >= 0 truncates it after that many raw bytes.
   function automatic int add_frame(int len, bit sum_ok, int cut);
      logic [7:0] raw[$];
      logic [7:0] sum;
      logic [7:0] d;
      logic [7:0] chk;
      int         keep;
      int         i;
      raw.push_back(len[15:8]);
      raw.push_back(len[7:0]);
      sum = '0;
      for (i = 0; i < len; i++) begin
         d = 8'($urandom_range(0, 255));
         raw.push_back(d);
         sum = sum + d;
      end
      chk = SUM_GOOD - sum;
      if (!sum_ok) chk = chk + 8'($urandom_range(1, 255));
      raw.push_back(chk);
      keep = (cut >= 0 && cut < raw.size()) ? cut : raw.size();
      stim_q.push_back(tracker.start_val);
      for (i = 0; i < keep; i++) add_coded(raw[i]);
      // dangling escape: the next delimiter gets unescaped into data
      if (cut >= 0 && tracker.start_val != tracker.esc_val && $urandom_range(0, 3) == 0)
         stim_q.push_back(tracker.esc_val);
      return keep + 1;
   endfunction

   function automatic int add_oversize();
      logic [15:0] len;
      int          i;
      len = 16'($urandom_range(MAX_FRAME - 2, 65535));
      stim_q.push_back(tracker.start_val);
      add_coded(len[15:8]);
      add_coded(len[7:0]);
      for (i = 0; i < MAX_FRAME - 1; i++) add_coded(8'($urandom_range(0, 255)));
      return MAX_FRAME + 2;
   endfunction

   task automatic gen_frames(int target);
      int counted;
      int r;
      int n;
      int len;
      int i;
      logic [7:0] b;
      counted = 0;
      while (counted < target) begin
         r = $urandom_range(0, 99);
         n = 0;
         if (r < 60) begin
            n = add_frame($urandom_range(0, 12), 1'b1, -1);
         end else if (r < 70) begin
            n = add_frame($urandom_range(0, 12), 1'b0, -1);
         end else if (r < 80) begin
            len = $urandom_range(0, 12);
            n = add_frame(len, 1'b1, $urandom_range(0, len + 2));
         end else if (r < 88) begin
            // line noise, hunted over unless a cut frame is still open; sometimes the escape value
            for (i = 0; i < $urandom_range(1, 5); i++) begin
               b = 8'($urandom_range(0, 255));
               if (b == tracker.start_val) b = tracker.esc_val;
               stim_q.push_back(b);
            end
         end else if (r < 95) begin
            n = add_frame($urandom_range(13, 90), 1'b1, -1);
         end else begin
            // broken frame: random bytes, ended by whatever delimiter comes next
            stim_q.push_back(tracker.start_val);
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) stim_q.push_back(8'($urandom_range(0, 255)));
            n++;
         end
         counted += n;
      end
   endtask

   initial begin
      logic [7:0] s;
      logic [7:0] e;
      int         n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: escape while hunting, zero length, escaped length/data/checksum,
      // delimiter inside frame (twice), bad checksum
      stim_q = '{8'h7D,
                 8'h7E, 8'h00, 8'h00, 8'hFF,
                 8'h7E, 8'h7D, 8'h20, 8'h01, 8'h7D, 8'h5E, 8'h81,
                 8'h7E, 8'h00, 8'h02, 8'h7D, 8'h7E,
                 8'h7E, 8'hFF, 8'hFF,
                 8'h7E, 8'h00, 8'h01, 8'h05, 8'h7D, 8'h20};
      send_all();

      write_settings(START_RESET, ESCAPE_RESET);
      gen_frames(PHASE_LOAD);
      send_all();

      write_settings(8'h00, 8'hFF);
      gen_frames(PHASE_LOAD / 2);
      n = add_oversize();
      gen_frames(PHASE_LOAD / 2);
      send_all();

      write_settings(8'hFF, 8'h00);
      gen_frames(PHASE_LOAD / 2);
      n = add_frame(MAX_FRAME - 3, 1'b1, -1);
      gen_frames(PHASE_LOAD / 2);
      send_all();

      // delimiter and escape share a value
      s = 8'($urandom_range(0, 255));
      write_settings(s, s);
      gen_frames(PHASE_LOAD);
      send_all();

      s = 8'($urandom_range(0, 255));
      e = 8'($urandom_range(0, 255));
      if (e == s) e = e ^ 8'h01;
      write_settings(s, e);
      gen_frames(PHASE_LOAD);
      send_all();

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.pending_results.size() != 0)
         tracker.report_mismatch($sformatf("%0d results never arrived",
                                           tracker.pending_results.size()));

      $display("sent %0d bytes under %0d delimiter/escape settings, checked %0d results",
               bytes_sent, settings_used, tracker.checked);
      $display("frame ends: %0d good, %0d bad checksum, %0d delimiter, %0d oversize",
               tracker.ends_seen[KIND_GOOD], tracker.ends_seen[KIND_BAD_SUM],
               tracker.ends_seen[KIND_DELIM], tracker.ends_seen[KIND_OVERSIZE]);
      if (tracker.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
